@@ sv/lpr_pkg.sv @@
// shared types and constants of the line pixel rasterizer
package lpr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOUR_BITS = 16;
    localparam int SIZE_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int CFG_IDX_BITS = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = CFG_IDX_BITS'(3);

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [COORD_BITS-1:0]  start_x;
        logic [COORD_BITS-1:0]  start_y;
        logic [COORD_BITS-1:0]  end_x;
        logic [COORD_BITS-1:0]  end_y;
        logic [COLOUR_BITS-1:0] colour_in;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [COLOUR_BITS-1:0] colour_out;
        logic                   last;
    } t_out_item;

    // canvas window from the configuration registers
    typedef struct packed {
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [SIZE_BITS-1:0]  width;
        logic [SIZE_BITS-1:0]  height;
    } t_canvas;

    // walker state computed from a load
    typedef struct packed {
        logic                       in_canvas;
        logic [COORD_BITS-1:0]      cur_x;
        logic [COORD_BITS-1:0]      cur_y;
        logic signed [ERR_BITS-1:0] err_term;
        logic signed [ERR_BITS-1:0] inc_straight;
        logic signed [ERR_BITS-1:0] inc_diag;
        logic [COORD_BITS-1:0]      remaining;
        logic                       x_major;
        logic                       minor_step_neg;
    } t_line_setup;

endpackage

@@ sv/line_pixel_rasterizer_top.sv @@
// top level of the midpoint line rasterizer
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries commands.
//   a load (cmd 0) gives two absolute endpoints and a colour; the line is
//   kept only if both endpoints lie in the canvas window, and a load never
//   yields a result. each step (cmd 1) on an active line yields one
//   canvas-relative pixel on the output channel (o_out_valid / i_out_ready
//   / o_out_data), last set on the final one of max(|dx|,|dy|)+1 pixels.
//   steps on an idle block are consumed with no result.
//   latency: a step's pixel is valid the cycle after its transfer.
//   throughput: one item per cycle while the receiver does not stall, set by the
//   single error-term add and compare in the walker; the result register lets
//   a new item enter while the previous pixel drains.
//   receiver stall: the pixel holds and o_in_ready drops until it is taken.
//   reset: no line active, output empty, canvas origin 0,0 and full size.
//   canvas registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
module line_pixel_rasterizer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lpr_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lpr_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [lpr_pkg::SIZE_BITS-1:0]       i_cfg_data
);
    import lpr_pkg::*;

    t_canvas     r_canvas;
    t_line_setup setup;

    // canvas configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas.origin_x <= '0;
            r_canvas.origin_y <= '0;
            r_canvas.width    <= {1'b1, {COORD_BITS{1'b0}}};
            r_canvas.height   <= {1'b1, {COORD_BITS{1'b0}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_canvas.origin_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_ORIGIN_Y: r_canvas.origin_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_WIDTH:    r_canvas.width    <= i_cfg_data;
                CFG_HEIGHT:   r_canvas.height   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lpr_line_setup u_setup (
        .i_item   (i_in_data),
        .i_canvas (r_canvas),
        .o_setup  (setup)
    );

    lpr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_in_data),
        .i_setup     (setup),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/lpr_line_setup.sv @@
// load path: window check, endpoint ordering and error term setup
module lpr_line_setup (
    input  lpr_pkg::t_in_item    i_item,
    input  lpr_pkg::t_canvas     i_canvas,
    output lpr_pkg::t_line_setup o_setup
);
    import lpr_pkg::*;

    function automatic logic in_window(input logic [COORD_BITS-1:0] v,
                                       input logic [COORD_BITS-1:0] org,
                                       input logic [SIZE_BITS-1:0]  size);
        logic [COORD_BITS-1:0] diff;
        diff = v - org;
        return (v >= org) && ({1'b0, diff} < size);
    endfunction

    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic                  x_major, swap;
    logic [COORD_BITS-1:0] fx, fy, lx, ly;
    logic [ERR_BITS-1:0]   dmin2, dmaj1, dmaj2;

    // canvas-relative endpoints and deltas
    always_comb begin
        sx = i_item.start_x - i_canvas.origin_x;
        ex = i_item.end_x   - i_canvas.origin_x;
        sy = i_item.start_y - i_canvas.origin_y;
        ey = i_item.end_y   - i_canvas.origin_y;
        dx = (sx > ex) ? sx - ex : ex - sx;
        dy = (sy > ey) ? sy - ey : ey - sy;
        x_major = dx >= dy;
        swap = (x_major && sx > ex) || (!x_major && sy > ey);
        fx = swap ? ex : sx;
        fy = swap ? ey : sy;
        lx = swap ? sx : ex;
        ly = swap ? sy : ey;
        dmaj = x_major ? dx : dy;
        dmin = x_major ? dy : dx;
    end

    // error term and increments
    always_comb begin
        dmin2 = {2'b00, dmin, 1'b0};
        dmaj1 = {3'b000, dmaj};
        dmaj2 = {2'b00, dmaj, 1'b0};
        o_setup.in_canvas = in_window(i_item.start_x, i_canvas.origin_x, i_canvas.width)
                         && in_window(i_item.end_x, i_canvas.origin_x, i_canvas.width)
                         && in_window(i_item.start_y, i_canvas.origin_y, i_canvas.height)
                         && in_window(i_item.end_y, i_canvas.origin_y, i_canvas.height);
        o_setup.cur_x          = fx;
        o_setup.cur_y          = fy;
        o_setup.err_term       = signed'(dmin2 - dmaj1);
        o_setup.inc_straight   = signed'(dmin2);
        o_setup.inc_diag       = signed'(dmin2 - dmaj2);
        o_setup.remaining      = dmaj;
        o_setup.x_major        = x_major;
        o_setup.minor_step_neg = x_major ? (ly < fy) : (lx < fx);
    end

endmodule

@@ sv/lpr_walker.sv @@
// line state, one midpoint step per step transfer, and the result register
module lpr_walker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lpr_pkg::t_in_item    i_item,
    input  lpr_pkg::t_line_setup i_setup,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lpr_pkg::t_out_item   o_out_data
);
    import lpr_pkg::*;

    logic                       r_active;
    logic [COORD_BITS-1:0]      r_cur_x, r_cur_y;
    logic signed [ERR_BITS-1:0] r_err, r_inc_straight, r_inc_diag;
    logic [COORD_BITS-1:0]      r_remaining;
    logic                       r_x_major, r_minor_neg;
    logic [COLOUR_BITS-1:0]     r_colour;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       in_fire, is_load, is_step, diag;
    logic [COORD_BITS-1:0]      n_cur_x, n_cur_y, minor_nxt;
    logic signed [ERR_BITS-1:0] n_err;

    // transfer accepted whenever the result register is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign is_load     = in_fire && (i_item.cmd == CMD_LOAD);
    assign is_step     = in_fire && (i_item.cmd == CMD_STEP) && r_active;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next position and error term
    always_comb begin
        diag      = r_err > 0;
        minor_nxt = r_x_major ? r_cur_y : r_cur_x;
        if (diag) begin
            minor_nxt = r_minor_neg ? minor_nxt - 1'b1 : minor_nxt + 1'b1;
        end
        n_err = diag ? r_err + r_inc_diag : r_err + r_inc_straight;
        if (r_x_major) begin
            n_cur_x = r_cur_x + 1'b1;
            n_cur_y = minor_nxt;
        end else begin
            n_cur_x = minor_nxt;
            n_cur_y = r_cur_y + 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (is_load) begin
                r_active <= i_setup.in_canvas;
            end else if (is_step && r_remaining == '0) begin
                r_active <= 1'b0;
            end
            if (is_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line datapath and result payload
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_cur_x        <= i_setup.cur_x;
            r_cur_y        <= i_setup.cur_y;
            r_err          <= i_setup.err_term;
            r_inc_straight <= i_setup.inc_straight;
            r_inc_diag     <= i_setup.inc_diag;
            r_remaining    <= i_setup.remaining;
            r_x_major      <= i_setup.x_major;
            r_minor_neg    <= i_setup.minor_step_neg;
            r_colour       <= i_item.colour_in;
        end else if (is_step && r_remaining != '0) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_err       <= n_err;
            r_remaining <= r_remaining - 1'b1;
        end
        if (is_step) begin
            r_out.pixel_x    <= r_cur_x;
            r_out.pixel_y    <= r_cur_y;
            r_out.colour_out <= r_colour;
            r_out.last       <= (r_remaining == '0);
        end
    end

endmodule

@@ sv/lpr_checker.sv @@
// port-level checks of the line rasterizer, bound to the top level
module lpr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input lpr_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready
);
    import lpr_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled pixel stays valid
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("pixel dropped under stall");

    // an empty result register always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a load transfer never produces a pixel
    a_load_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == CMD_LOAD)
            && !(o_out_valid && !i_out_ready) |=> !o_out_valid)
        else $error("pixel after load transfer");

endmodule

bind line_pixel_rasterizer_top lpr_checker u_lpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

@@ tb/sv/line_pixel_rasterizer_top_tb.sv @@
// self-checking testbench for the line pixel rasterizer top level
module line_pixel_rasterizer_top_tb;
    import lpr_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int SETTLE       = 6;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int N_PHASES     = 11;
    localparam int PHASE_ITEMS  = 175;
    localparam int DIR_ROWS     = 35;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_CANVAS,
        ROW_PREDICT,
        ROW_NO_PIXEL,
        ROW_PIXEL
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_canvas   canvas;
        t_in_item  item;
        t_out_item pix;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_data = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_data;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_ORIGIN_X;
    logic [SIZE_BITS-1:0]    i_cfg_data = '0;

    // line walker mirror and canvas copy
    t_canvas                    cv;
    logic                       ln_active;
    logic [COORD_BITS-1:0]      ln_x;
    logic [COORD_BITS-1:0]      ln_y;
    logic signed [ERR_BITS-1:0] ln_err;
    logic signed [ERR_BITS-1:0] ln_inc_s;
    logic signed [ERR_BITS-1:0] ln_inc_d;
    logic [COORD_BITS-1:0]      ln_rem;
    logic                       ln_xmaj;
    logic                       ln_neg;
    logic [COLOUR_BITS-1:0]     ln_colour;

    t_out_item expected_pixels [$];
    t_out_item want_pix;
    t_dir_row  dir_tab [DIR_ROWS];
    bit        stall_on = 1'b1;
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        n_sent = 0;
    int        n_useful = 0;

    line_pixel_rasterizer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("line_pixel_rasterizer_top_tb: done, errors");
            $finish;
        end
    end

    function automatic bit in_span(int v, int org, int size);
        return v >= org && v - org < size;
    endfunction

    // midpoint walker: returns 1 when the item yields a pixel
    function automatic bit rasterize_item(input t_in_item it, output t_out_item px);
        int sx, sy, ex, ey, dx, dy, dmaj, dmin, t;
        bit diag;
        px = '0;
        if (it.cmd == CMD_LOAD) begin
            sx = it.start_x;
            sy = it.start_y;
            ex = it.end_x;
            ey = it.end_y;
            if (!in_span(sx, cv.origin_x, cv.width) || !in_span(ex, cv.origin_x, cv.width) ||
                !in_span(sy, cv.origin_y, cv.height) || !in_span(ey, cv.origin_y, cv.height)) begin
                ln_active = 1'b0;
                return 1'b0;
            end
            sx -= cv.origin_x;
            ex -= cv.origin_x;
            sy -= cv.origin_y;
            ey -= cv.origin_y;
            dx = (sx > ex) ? sx - ex : ex - sx;
            dy = (sy > ey) ? sy - ey : ey - sy;
            ln_xmaj = dx >= dy;
            // walk so that the major axis increases
            if ((ln_xmaj && sx > ex) || (!ln_xmaj && sy > ey)) begin
                t = sx; sx = ex; ex = t;
                t = sy; sy = ey; ey = t;
            end
            ln_neg = ln_xmaj ? (ey < sy) : (ex < sx);
            dmaj = ln_xmaj ? dx : dy;
            dmin = ln_xmaj ? dy : dx;
            ln_err = ERR_BITS'(2 * dmin - dmaj);
            ln_inc_s = ERR_BITS'(2 * dmin);
            ln_inc_d = ERR_BITS'(2 * (dmin - dmaj));
            ln_rem = COORD_BITS'(dmaj);
            ln_x = COORD_BITS'(sx);
            ln_y = COORD_BITS'(sy);
            ln_colour = it.colour_in;
            ln_active = 1'b1;
            return 1'b0;
        end
        if (!ln_active) return 1'b0;
        px.pixel_x = ln_x;
        px.pixel_y = ln_y;
        px.colour_out = ln_colour;
        if (ln_rem == 0) begin
            px.last = 1'b1;
            ln_active = 1'b0;
            return 1'b1;
        end
        // minor axis moves while the error term is positive
        diag = ln_err > 0;
        if (ln_xmaj) begin
            ln_x = ln_x + 1'b1;
            if (diag) ln_y = ln_neg ? ln_y - 1'b1 : ln_y + 1'b1;
        end else begin
            ln_y = ln_y + 1'b1;
            if (diag) ln_x = ln_neg ? ln_x - 1'b1 : ln_x + 1'b1;
        end
        ln_err = ln_err + (diag ? ln_inc_d : ln_inc_s);
        ln_rem = ln_rem - 1'b1;
        return 1'b1;
    endfunction

    // step command; endpoint fields carry noise the block must ignore
    function automatic t_in_item step_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.cmd = CMD_STEP;
        return it;
    endfunction

    function automatic t_in_item load_item(int sx, int sy, int ex, int ey, int c);
        t_in_item it;
        it.cmd = CMD_LOAD;
        it.start_x = COORD_BITS'(sx);
        it.start_y = COORD_BITS'(sy);
        it.end_x = COORD_BITS'(ex);
        it.end_y = COORD_BITS'(ey);
        it.colour_in = COLOUR_BITS'(c);
        return it;
    endfunction

    // a coordinate close to v, kept inside lo..hi
    function automatic int near(int v, int lo, int hi, int reach);
        int a, b;
        a = (v - reach < lo) ? lo : v - reach;
        b = (v + reach > hi) ? hi : v + reach;
        return int'($urandom_range(b, a));
    endfunction

    // a coordinate outside lo..hi, at the edge or further off; any coordinate if lo..hi is the full range
    function automatic int outside(int lo, int hi);
        if (lo > 0 && (hi == COORD_MAX || $urandom_range(0, 1) == 1))
            return ($urandom_range(0, 1) == 1) ? lo - 1 : int'($urandom_range(lo - 1, 0));
        if (hi < COORD_MAX)
            return ($urandom_range(0, 1) == 1) ? hi + 1 : int'($urandom_range(COORD_MAX, hi + 1));
        return int'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_origin();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COORD_BITS'($urandom_range(0, 63));
            2: return COORD_BITS'($urandom_range(3900, COORD_MAX));
            default: return COORD_BITS'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 4))
            0: return SIZE_BITS'(COORD_MAX + 1);
            1: return SIZE_BITS'(1);
            2: return SIZE_BITS'($urandom_range(1, 64));
            3: return SIZE_BITS'($urandom_range(1, 600));
            default: return SIZE_BITS'($urandom_range(1, COORD_MAX + 1));
        endcase
    endfunction

    // one input transfer, then the expectation it causes
    task automatic push_item(input t_in_item it, input t_row_kind kind, input t_out_item typed);
        t_out_item px;
        bit got;
        if (stall_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        got = rasterize_item(it, px);
        if (kind == ROW_PIXEL) expected_pixels.push_back(typed);
        else if (kind == ROW_PREDICT && got) expected_pixels.push_back(px);
        n_sent++;
        if (got || (it.cmd == CMD_LOAD && ln_active)) n_useful++;
    endtask

    // wait until every pixel has come out and the walker has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // all four canvas registers, write enable held across them
    task automatic write_canvas(input t_canvas c);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ORIGIN_X;
        i_cfg_data <= {1'($urandom), c.origin_x};
        @(posedge i_clk);
        i_cfg_index <= CFG_ORIGIN_Y;
        i_cfg_data <= {1'($urandom), c.origin_y};
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= c.width;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= c.height;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cv = c;
    endtask

    // one random line: load, then mostly its full run of steps
    task automatic draw_line();
        t_in_item it;
        int lo_x, hi_x, lo_y, hi_y, sx, sy, ex, ey, r, reach, pixels, n;
        it = step_item();
        it.cmd = CMD_LOAD;
        sx = it.start_x;
        sy = it.start_y;
        ex = it.end_x;
        ey = it.end_y;
        lo_x = cv.origin_x;
        lo_y = cv.origin_y;
        hi_x = lo_x + int'(cv.width) - 1;
        hi_y = lo_y + int'(cv.height) - 1;
        if (hi_x > COORD_MAX) hi_x = COORD_MAX;
        if (hi_y > COORD_MAX) hi_y = COORD_MAX;
        if (hi_x >= lo_x && hi_y >= lo_y) begin
            r = $urandom_range(0, 199);
            reach = (r == 0) ? COORD_MAX : (r < 20) ? 255 : 12;
            sx = $urandom_range(hi_x, lo_x);
            sy = $urandom_range(hi_y, lo_y);
            ex = near(sx, lo_x, hi_x, reach);
            ey = near(sy, lo_y, hi_y, reach);
            // broken load: one endpoint off the canvas
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: sx = outside(lo_x, hi_x);
                    1: ex = outside(lo_x, hi_x);
                    2: sy = outside(lo_y, hi_y);
                    default: ey = outside(lo_y, hi_y);
                endcase
            end
        end
        it.start_x = COORD_BITS'(sx);
        it.start_y = COORD_BITS'(sy);
        it.end_x = COORD_BITS'(ex);
        it.end_y = COORD_BITS'(ey);
        push_item(it, ROW_PREDICT, '0);
        pixels = ln_active ? int'(ln_rem) + 1 : 0;
        case ($urandom_range(0, 7))
            0: n = $urandom_range(pixels, 0);
            1: n = pixels + $urandom_range(1, 3);
            default: n = pixels;
        endcase
        repeat (n) push_item(step_item(), ROW_PREDICT, '0);
    endtask

    // receiver with random stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // compare each pixel transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel: x %0d y %0d colour %h last %0d",
                       o_out_data.pixel_x, o_out_data.pixel_y,
                       o_out_data.colour_out, o_out_data.last);
                mismatch_cnt++;
            end else begin
                want_pix = expected_pixels.pop_front();
                if (o_out_data.pixel_x !== want_pix.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want_pix.pixel_x, o_out_data.pixel_x);
                    mismatch_cnt++;
                end
                if (o_out_data.pixel_y !== want_pix.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want_pix.pixel_y, o_out_data.pixel_y);
                    mismatch_cnt++;
                end
                if (o_out_data.colour_out !== want_pix.colour_out) begin
                    $error("colour_out: expected %h, got %h",
                           want_pix.colour_out, o_out_data.colour_out);
                    mismatch_cnt++;
                end
                if (o_out_data.last !== want_pix.last) begin
                    $error("last: expected %0d, got %0d", want_pix.last, o_out_data.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_canvas c;
        int base_u, base_s;
        cv = '{12'd0, 12'd0, 13'd4096, 13'd4096};
        ln_active = 1'b0;
        ln_x = '0;
        ln_y = '0;
        ln_err = '0;
        ln_inc_s = '0;
        ln_inc_d = '0;
        ln_rem = '0;
        ln_xmaj = 1'b0;
        ln_neg = 1'b0;
        ln_colour = '0;

        dir_tab = '{
            // step on an idle block, then single point lines at both corners
            '{ROW_NO_PIXEL, '0, step_item(), '0},
            '{ROW_NO_PIXEL, '0, load_item(0, 0, 0, 0, 'h0000), '0},
            '{ROW_PIXEL, '0, step_item(), '{12'd0, 12'd0, 16'h0000, 1'b1}},
            '{ROW_NO_PIXEL, '0, load_item(4095, 4095, 4095, 4095, 'hFFFF), '0},
            '{ROW_PIXEL, '0, step_item(), '{12'd4095, 12'd4095, 16'hFFFF, 1'b1}},
            '{ROW_NO_PIXEL, '0, step_item(), '0},
            // horizontal, reversed
            '{ROW_NO_PIXEL, '0, load_item(3, 5, 0, 5, 'h1234), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            // vertical, reversed, cut short by the next load
            '{ROW_NO_PIXEL, '0, load_item(7, 9, 7, 6, 'h5555), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            // diagonal with a falling minor axis
            '{ROW_NO_PIXEL, '0, load_item(10, 10, 7, 13, 'hAAAA), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            // steep line
            '{ROW_NO_PIXEL, '0, load_item(20, 30, 21, 27, 'h0F0F), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            // small window: one off below on x, one off above on y, upper edges inside
            '{ROW_CANVAS, '{12'd100, 12'd200, 13'd50, 13'd60}, '0, '0},
            '{ROW_NO_PIXEL, '0, load_item(99, 200, 110, 210, 'h3C3C), '0},
            '{ROW_NO_PIXEL, '0, step_item(), '0},
            '{ROW_NO_PIXEL, '0, load_item(149, 259, 147, 258, 'hC3C3), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_PREDICT, '0, step_item(), '0},
            '{ROW_NO_PIXEL, '0, load_item(100, 260, 100, 260, 'h0001), '0},
            '{ROW_NO_PIXEL, '0, step_item(), '0},
            // empty canvas rejects everything
            '{ROW_CANVAS, '{12'd0, 12'd0, 13'd0, 13'd0}, '0, '0},
            '{ROW_NO_PIXEL, '0, load_item(0, 0, 0, 0, 'h00FF), '0},
            '{ROW_NO_PIXEL, '0, step_item(), '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CANVAS) begin
                drain();
                write_canvas(dir_tab[i].canvas);
            end else begin
                push_item(dir_tab[i].item, dir_tab[i].kind, dir_tab[i].pix);
            end
        end

        // random phases, each with its own canvas; the last runs flat out
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: c = '{12'd0, 12'd0, 13'd4096, 13'd4096};
                1: c = '{12'd4095, 12'd4095, 13'd1, 13'd1};
                2: c = '{12'd4095, 12'd0, 13'd4096, 13'd4096};
                3: c = '{12'd0, 12'd4095, 13'd4096, 13'd0};
                N_PHASES - 1: c = '{12'd0, 12'd0, 13'd4096, 13'd4096};
                default: c = '{pick_origin(), pick_origin(), pick_size(), pick_size()};
            endcase
            drain();
            write_canvas(c);
            stall_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            base_u = n_useful;
            base_s = n_sent;
            while (n_useful - base_u < PHASE_ITEMS && n_sent - base_s < 2 * PHASE_ITEMS)
                draw_line();
        end

        drain();
        if (mismatch_cnt == 0) begin
            $display("line_pixel_rasterizer_top_tb: done, clean");
        end else begin
            $display("line_pixel_rasterizer_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lpr_pkg.sv
sv/lpr_line_setup.sv
sv/lpr_walker.sv
sv/line_pixel_rasterizer_top.sv
sv/lpr_checker.sv
tb/sv/line_pixel_rasterizer_top_tb.sv
